// File: src/ghsd_pkg.sv
// Shared types, constants and the base32 character decode for the geohash decoder.
// No dependencies; used by the channel interfaces and by geohash_string_decoder.
package ghsd_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned BITS_W  = 6;
  localparam int unsigned LAT_W   = 60;
  localparam int unsigned LON_W   = 61;
  localparam int unsigned ACC_W   = 60;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned PAIR_W  = 4;
  localparam int unsigned FRAC    = 52;

  localparam logic [POS_W-1:0] MAX_CHARS = 5'd24;

  // Spans and offsets in degrees, offsets already in Q.52
  localparam logic [67:0] LAT_SPAN = 68'd180;
  localparam logic [68:0] LON_SPAN = 69'd360;
  localparam logic [LAT_W-1:0] LAT_OFS = 60'd90 << FRAC;
  localparam logic [LON_W-1:0] LON_OFS = 61'd180 << FRAC;

  typedef logic [5:0] digit_t;

  // 0..31 real digits, then two marker codes
  localparam digit_t DIG_NUL = 6'd32;
  localparam digit_t DIG_BAD = 6'd33;

  // Base32 geohash alphabet, either case; codes of 128 and up fall through as bad
  function automatic digit_t digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] lc;
    digit_t d;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      lc = c + 8'd32;
    end
    if (c == 8'h00) begin
      d = DIG_NUL;
    end else if (lc >= 8'h30 && lc <= 8'h39) begin
      d = 6'(lc - 8'h30);
    end else if (lc >= 8'h62 && lc <= 8'h68) begin
      d = 6'(lc - 8'h62) + 6'd10;
    end else if (lc == 8'h6A || lc == 8'h6B) begin
      d = 6'(lc - 8'h6A) + 6'd17;
    end else if (lc == 8'h6D || lc == 8'h6E) begin
      d = 6'(lc - 8'h6D) + 6'd19;
    end else if (lc >= 8'h70 && lc <= 8'h7A) begin
      d = 6'(lc - 8'h70) + 6'd21;
    end else begin
      d = DIG_BAD;
    end
    return d;
  endfunction

endpackage

// File: src/ghsd_in_if.sv
// Character input channel: valid/ready with one geohash character and a last flag.
// Depends on ghsd_pkg for field widths.
interface ghsd_in_if import ghsd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

// File: src/ghsd_out_if.sv
// Result channel: valid/ready with status, bits per axis and the decoded corner.
// Depends on ghsd_pkg for field widths.
interface ghsd_out_if import ghsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [BITS_W-1:0]        bits_per_axis;
  logic signed [LAT_W-1:0]  lat_deg;
  logic signed [LON_W-1:0]  lon_deg;

  modport source (output valid, status, bits_per_axis, lat_deg, lon_deg, input ready);
  modport sink   (input valid, status, bits_per_axis, lat_deg, lon_deg, output ready);
endinterface

// File: src/geohash_string_decoder.sv
// Geohash string decoder: one character per transfer in, one corner result per string out.
// Depends on ghsd_pkg, ghsd_in_if and ghsd_out_if.
//
// Usage:
//   in_chan carries one ASCII character per transfer; last marks the final one.
//   Characters map to base32 digits and are de-interleaved pairwise into
//   longitude/latitude bit accumulators as they arrive. Only a transfer with
//   last set produces a result on out_chan: status, bits per axis, and the
//   lower-left corner of the cell as signed Q.52 degrees (zeros on bad input).
//   Throughput: one character per cycle while out_chan accepts results.
//   A string's result is registered in the finish register on the transfer of
//   its last character, then passes through the scaling multiply into the
//   output register.
//   A stalled out_chan holds its result; the finish register absorbs one more
//   string end, after which in_chan.ready drops until the output drains.
//   Reset (synchronous, rst_n low) empties both registers and clears the
//   accumulated string state.
module geohash_string_decoder import ghsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ghsd_in_if.sink    in_chan,
  ghsd_out_if.source out_chan
);

  // Per-string state
  logic [POS_W-1:0] char_pos_r, char_pos_nxt;
  logic [4:0]       first_digit_r, first_digit_nxt;
  logic [ACC_W-1:0] lat_bits_r, lat_bits_nxt;
  logic [ACC_W-1:0] lon_bits_r, lon_bits_nxt;
  logic             stopped_r, stopped_nxt;
  logic             bad_char_r, bad_char_nxt;

  // Finish register
  logic              fin_vld_r;
  logic              fin_bad_r, fin_bad_nxt;
  logic [BITS_W-1:0] fin_bits_r, fin_bits_nxt;
  logic [ACC_W-1:0]  fin_lat_r, fin_lat_nxt;
  logic [ACC_W-1:0]  fin_lon_r, fin_lon_nxt;

  // Output register
  logic              out_vld_r;
  logic              out_status_r;
  logic [BITS_W-1:0] out_bits_r;
  logic [LAT_W-1:0]  out_lat_r, out_lat_nxt;
  logic [LON_W-1:0]  out_lon_r, out_lon_nxt;

  logic   in_take, out_take, fin_take;
  digit_t dig;
  logic [4:0]        dig_lo;
  logic [ACC_W-1:0]  lat_end, lon_end;
  logic [POS_W-1:0]  pos_end;
  logic [PAIR_W-1:0] pairs;
  logic [BITS_W-1:0] bits;
  logic [67:0]       lat_prod;
  logic [68:0]       lon_prod;

  assign out_take      = !out_vld_r || out_chan.ready;
  assign fin_take      = fin_vld_r && out_take;
  assign in_chan.ready = !fin_vld_r || out_take;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign dig    = digit_of(in_chan.ch);
  assign dig_lo = (dig == DIG_NUL) ? 5'd0 : dig[4:0];

  // Character step
  always_comb begin
    char_pos_nxt    = char_pos_r;
    first_digit_nxt = first_digit_r;
    lat_bits_nxt    = lat_bits_r;
    lon_bits_nxt    = lon_bits_r;
    stopped_nxt     = stopped_r;
    bad_char_nxt    = bad_char_r;
    if (!stopped_r && !bad_char_r && char_pos_r < MAX_CHARS) begin
      if (!char_pos_r[0]) begin
        if (dig == DIG_NUL) begin
          stopped_nxt = 1'b1;
        end else if (dig == DIG_BAD) begin
          bad_char_nxt = 1'b1;
        end else begin
          first_digit_nxt = dig[4:0];
          char_pos_nxt    = char_pos_r + 5'd1;
        end
      end else if (dig == DIG_BAD) begin
        bad_char_nxt = 1'b1;
      end else begin
        // longitude takes the even interleave positions, latitude the odd
        lon_bits_nxt = {lon_bits_r[ACC_W-6:0], first_digit_r[4], first_digit_r[2],
                        first_digit_r[0], dig_lo[3], dig_lo[1]};
        lat_bits_nxt = {lat_bits_r[ACC_W-6:0], first_digit_r[3], first_digit_r[1],
                        dig_lo[4], dig_lo[2], dig_lo[0]};
        char_pos_nxt = char_pos_r + 5'd1;
        if (dig == DIG_NUL) begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  // String end: complete a dangling pair with zero, left-align the accumulators
  always_comb begin
    lat_end = lat_bits_nxt;
    lon_end = lon_bits_nxt;
    pos_end = char_pos_nxt;
    if (!bad_char_nxt && !stopped_nxt && char_pos_nxt[0]) begin
      lon_end = {lon_bits_nxt[ACC_W-6:0], first_digit_nxt[4], first_digit_nxt[2],
                 first_digit_nxt[0], 2'b00};
      lat_end = {lat_bits_nxt[ACC_W-6:0], first_digit_nxt[3], first_digit_nxt[1], 3'b000};
      pos_end = char_pos_nxt + 5'd1;
    end
    pairs        = pos_end[POS_W-1:1];
    bits         = 6'({pairs, 2'b00}) + 6'(pairs);
    fin_bad_nxt  = bad_char_nxt;
    fin_bits_nxt = bad_char_nxt ? '0 : bits;
    fin_lat_nxt  = lat_end << (6'(ACC_W) - bits);
    fin_lon_nxt  = lon_end << (6'(ACC_W) - bits);
  end

  // floor(span * v * 2^52 / 2^bits) with v left-aligned in 60 bits: (aligned * span) >> 8
  assign lat_prod = 68'(fin_lat_r) * LAT_SPAN;
  assign lon_prod = 69'(fin_lon_r) * LON_SPAN;

  always_comb begin
    if (fin_bad_r) begin
      out_lat_nxt = '0;
      out_lon_nxt = '0;
    end else begin
      out_lat_nxt = lat_prod[67:8] - LAT_OFS;
      out_lon_nxt = lon_prod[68:8] - LON_OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r    <= '0;
      first_digit_r <= '0;
      lat_bits_r    <= '0;
      lon_bits_r    <= '0;
      stopped_r     <= 1'b0;
      bad_char_r    <= 1'b0;
      fin_vld_r     <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (in_take) begin
        if (in_chan.last) begin
          char_pos_r    <= '0;
          first_digit_r <= '0;
          lat_bits_r    <= '0;
          lon_bits_r    <= '0;
          stopped_r     <= 1'b0;
          bad_char_r    <= 1'b0;
        end else begin
          char_pos_r    <= char_pos_nxt;
          first_digit_r <= first_digit_nxt;
          lat_bits_r    <= lat_bits_nxt;
          lon_bits_r    <= lon_bits_nxt;
          stopped_r     <= stopped_nxt;
          bad_char_r    <= bad_char_nxt;
        end
      end
      if (in_take && in_chan.last) begin
        fin_vld_r <= 1'b1;
      end else if (fin_take) begin
        fin_vld_r <= 1'b0;
      end
      if (fin_take) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take && in_chan.last) begin
      fin_bad_r  <= fin_bad_nxt;
      fin_bits_r <= fin_bits_nxt;
      fin_lat_r  <= fin_lat_nxt;
      fin_lon_r  <= fin_lon_nxt;
    end
    if (fin_take) begin
      out_status_r <= fin_bad_r;
      out_bits_r   <= fin_bits_r;
      out_lat_r    <= out_lat_nxt;
      out_lon_r    <= out_lon_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.bits_per_axis = out_bits_r;
  assign out_chan.lat_deg       = out_lat_r;
  assign out_chan.lon_deg       = out_lon_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    char_pos_r <= MAX_CHARS)
    else $error("character position beyond limit");

  a_stop_even: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !char_pos_r[0])
    else $error("terminator left a half pair");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_chan.last) |=> (fin_vld_r && char_pos_r == '0 && !stopped_r && !bad_char_r))
    else $error("string end did not clear state or load finish register");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r) |->
      (out_bits_r == '0 && out_lat_r == '0 && out_lon_r == '0))
    else $error("invalid result carries non-zero fields");

endmodule
